>>> src/blids_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blids_pkg
// Shared sizes, operation codes and cell control types for the bounded list.
// ----------------------------------------------------------------------------
package blids_pkg;

   // list capacity and derived widths
   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W      = (CNT_W > 6) ? CNT_W : 6;
   localparam int DATA_W     = 32;

   // operation codes carried by an item
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_COPY   = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_SWAP   = 3'd3;
   localparam logic [2:0] OP_APPEND = 3'd4;

   // command broadcast to every cell
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH,
      CMD_DELETE,
      CMD_APPEND,
      CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [CMP_W-1:0] pos;
   } cell_ctl_type;

endpackage

>>> src/blids_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blids_cell
// One list slot: holds an entry and takes a neighbor's entry or the inserted value on command.
// ----------------------------------------------------------------------------
module blids_cell
   import blids_pkg::*;
(
   input  logic              clock,
   input  logic [CMP_W-1:0]  cell_idx,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] left_val,
   input  logic [DATA_W-1:0] right_val,
   input  logic [DATA_W-1:0] ins_val,
   output logic [DATA_W-1:0] entry_val
);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   // pick the next entry from the broadcast command
   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         CMD_PUSH: begin
            entry_in = left_val;
         end
         CMD_DELETE: begin
            if (cell_idx >= ctl.pos) begin
               entry_in = right_val;
            end
         end
         CMD_APPEND: begin
            if (cell_idx == ctl.pos) begin
               entry_in = ins_val;
            end
         end
         CMD_ROTATE: begin
            entry_in = right_val;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // entry storage, undefined until written
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_val = entry_ff;

endmodule

>>> src/bounded_list_insert_delete_swap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_swap
// Bounded ordered list of signed values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// An item is applied in the cycle it is accepted: push shifts every cell,
// delete shifts the cells from the deleted index on and append writes
// one cell. The whole list is then listed by rotating the cell row one
// place per cycle while the result side does not stall and taking the
// front cell, so a listing passes all LIST_DEPTH cells (64) across the
// front, of which the first entry_count produce results. A swap first
// makes one extra full rotation to pick up the far entry. A new item is
// taken once the rotation ends, while the final result may still be
// waiting in the output register.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_swap
   import blids_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_index_a,
   input  logic [5:0]         req_index_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value_res,
   output logic [5:0]         rsp_position,
   output logic               rsp_last,
   output logic               rsp_refused
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(LIST_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LIST_DEPTH);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic              refused_ff, refused_in;
   logic              swap_ff, swap_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [DATA_W-1:0] hi_val_ff, hi_val_in;
   logic [DATA_W-1:0] lo_val_ff, lo_val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [5:0]        rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_refused_ff, rsp_refused_in;

   cell_ctl_type      cell_ctl;
   logic [DATA_W-1:0] cell_val [LIST_DEPTH];
   logic [DATA_W-1:0] wrap_val;
   logic [DATA_W-1:0] out_val;

   logic              accept;
   logic              advance;
   logic              full;
   logic [CMP_W-1:0]  ia_ext, ib_ext, count_ext, step_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == FULL_CNT);
   assign ia_ext    = CMP_W'(req_index_a);
   assign ib_ext    = CMP_W'(req_index_b);
   assign count_ext = CMP_W'(count_ff);
   assign step_ext  = CMP_W'(step_ff);

   // sequencer: apply the operation, optional swap scan, then listing
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      refused_in     = refused_ff;
      swap_in        = swap_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      hi_val_in      = hi_val_ff;
      lo_val_in      = lo_val_ff;
      cell_ctl.cmd   = CMD_HOLD;
      cell_ctl.pos   = '0;
      out_val        = cell_val[0];
      wrap_val       = cell_val[0];
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_refused_in = rsp_refused_ff;

      // free the output register once its result is taken
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               refused_in = 1'b0;
               swap_in    = 1'b0;
               step_in    = '0;
               state_in   = ST_EMIT;
               case (req_op)
                  OP_PUSH: begin
                     if (full) begin
                        refused_in = 1'b1;
                     end else begin
                        cell_ctl.cmd = CMD_PUSH;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (ia_ext < count_ext) begin
                        cell_ctl.cmd = CMD_DELETE;
                        cell_ctl.pos = ia_ext;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  OP_SWAP: begin
                     if (ia_ext < count_ext && ib_ext < count_ext &&
                         req_index_a != req_index_b) begin
                        swap_in  = 1'b1;
                        state_in = ST_SCAN;
                        if (req_index_a < req_index_b) begin
                           lo_in = IDX_W'(req_index_a);
                           hi_in = IDX_W'(req_index_b);
                        end else begin
                           lo_in = IDX_W'(req_index_b);
                           hi_in = IDX_W'(req_index_a);
                        end
                     end
                  end
                  OP_APPEND: begin
                     if (full) begin
                        refused_in = 1'b1;
                     end else begin
                        cell_ctl.cmd = CMD_APPEND;
                        cell_ctl.pos = count_ext;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  OP_COPY: begin
                     cell_ctl.cmd = CMD_HOLD;
                  end
                  default: begin
                     cell_ctl.cmd = CMD_HOLD;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // full rotation to capture the entry at the higher swap index
            cell_ctl.cmd = CMD_ROTATE;
            if (step_ff == hi_ff) begin
               hi_val_in = cell_val[0];
            end
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_EMIT: begin
            if (advance) begin
               cell_ctl.cmd = CMD_ROTATE;
               // swap is applied as the two entries pass the front
               if (swap_ff && step_ff == lo_ff) begin
                  out_val   = hi_val_ff;
                  lo_val_in = cell_val[0];
               end else if (swap_ff && step_ff == hi_ff) begin
                  out_val = lo_val_ff;
               end
               wrap_val       = out_val;
               rsp_valid_in   = (step_ext < count_ext);
               rsp_value_in   = out_val;
               rsp_pos_in     = 6'(step_ff);
               rsp_last_in    = ((step_ext + 1'b1) == count_ext);
               rsp_refused_in = refused_ff;
               if (step_ff == LAST_STEP) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         refused_ff   <= 1'b0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         refused_ff   <= refused_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      hi_val_ff      <= hi_val_in;
      lo_val_ff      <= lo_val_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_refused_ff <= rsp_refused_in;
   end

   // row of cells, front at index 0, front wraps to the back on rotation
   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [DATA_W-1:0] left_val;
      logic [DATA_W-1:0] right_val;

      if (k == 0) begin : g_front
         assign left_val = req_value;
      end else begin : g_mid_l
         assign left_val = cell_val[k-1];
      end

      if (k == LIST_DEPTH - 1) begin : g_back
         assign right_val = wrap_val;
      end else begin : g_mid_r
         assign right_val = cell_val[k+1];
      end

      blids_cell u_cell (
         .clock     (clock),
         .cell_idx  (CMP_W'(k)),
         .ctl       (cell_ctl),
         .left_val  (left_val),
         .right_val (right_val),
         .ins_val   (req_value),
         .entry_val (cell_val[k])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_refused   = rsp_refused_ff;

endmodule
